// ===== rtl/rbd_pkg.sv =====
package rbd_pkg;

   // Default number of words held by the deque.
   localparam int unsigned DEPTH_DEFAULT = 8;

   // Fixed field widths of the request and response beats.
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned OCC_W    = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_REAR  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_REAR   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

endpackage

// ===== rtl/ring_buffer_deque_unit.sv =====
// Double-ended queue of DEPTH 32-bit words held in a circular store.
//
// Request channel (req_valid/req_ready): each beat carries req_kind (push front,
// push rear, pop front, pop rear) and req_push_value, which is used only by pushes.
// Response channel (rsp_valid/rsp_ready): exactly one beat per request, in request
// order, with rsp_status (done, overflow, underflow), rsp_popped_value (the word
// removed by a successful pop, else zero) and rsp_occupancy (words held afterwards,
// kept to its low four bits).
//
// Each accepted beat passes through stage one and then the response register, which
// drives rsp_valid. Throughput is one request per cycle while the response side
// does not stall: the pointers and count update at the accepting edge and the store
// is read or written in that same cycle, so the next request already sees the new
// state. The registered read of the store sets the extra pipeline stage.
//
// Synchronous reset empties the queue and drops any beats in flight; the store
// contents are not cleared, since a pop only reads words that a push wrote.
// When the receiver holds rsp_ready low, the response register and the stage in
// front of it hold their beats and req_ready falls once both are full.
module ring_buffer_deque_unit #(
   parameter int unsigned DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbd_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [rbd_pkg::WORD_W-1:0]   req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rbd_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [rbd_pkg::WORD_W-1:0]   rsp_popped_value,
   output logic [rbd_pkg::OCC_W-1:0]           rsp_occupancy
);
   import rbd_pkg::*;

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   // Circular store; written by pushes, read by pops.
   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Queue pointers and count, updated at the accepting edge.
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Stage one: waits for the store read data.
   logic             s1_valid_ff, s1_valid_in;
   status_type       s1_status_ff, s1_status_in;
   logic             s1_pop_ok_ff, s1_pop_ok_in;
   logic [OCC_W-1:0] s1_occ_ff, s1_occ_in;

   // Stage two: the response register.
   logic             s2_valid_ff, s2_valid_in;
   status_type       s2_status_ff;
   logic [WORD_W-1:0] s2_popped_ff;
   logic [OCC_W-1:0] s2_occ_ff;

   kind_type         kind;
   logic             accept;
   logic             s2_load;
   logic             s1_move;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] head_dn;
   logic [IDX_W-1:0] head_up;
   logic [IDX_W-1:0] tail_dn;
   logic [IDX_W-1:0] tail_up;

   assign kind    = kind_type'(req_kind);
   assign s2_load = !s2_valid_ff || rsp_ready;
   assign s1_move = s1_valid_ff && s2_load;
   assign req_ready = !s1_valid_ff || s2_load;
   assign accept  = req_valid && req_ready;

   assign head_dn = (head_ff == '0) ? IDX_LAST : head_ff - IDX_W'(1);
   assign head_up = (head_ff == IDX_LAST) ? '0 : head_ff + IDX_W'(1);
   assign tail_dn = (tail_ff == '0) ? IDX_LAST : tail_ff - IDX_W'(1);
   assign tail_up = (tail_ff == IDX_LAST) ? '0 : tail_ff + IDX_W'(1);

   // Request decode: decide the outcome, the store access and the new pointers.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      s1_status_in = STATUS_DONE;
      s1_pop_ok_in = 1'b0;
      case (kind)
         KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
            if (count_ff == CNT_FULL) begin
               s1_status_in = STATUS_OVERFLOW;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  // An empty queue restarts at slot zero.
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (kind == KIND_PUSH_FRONT) begin
                  head_in = head_dn;
                  wr_addr = head_dn;
               end else begin
                  tail_in = tail_up;
                  wr_addr = tail_up;
               end
            end
         end
         KIND_POP_FRONT, KIND_POP_REAR: begin
            if (count_ff == '0) begin
               s1_status_in = STATUS_UNDERFLOW;
            end else begin
               rd_en        = accept;
               s1_pop_ok_in = 1'b1;
               count_in     = count_ff - CNT_W'(1);
               rd_addr      = (kind == KIND_POP_FRONT) ? head_ff : tail_ff;
               if (count_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (kind == KIND_POP_FRONT) begin
                  head_in = head_up;
               end else begin
                  tail_in = tail_dn;
               end
            end
         end
         default: begin
            s1_status_in = STATUS_DONE;
         end
      endcase
      s1_occ_in = OCC_W'(count_in);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   // The store. Read data holds until the next pop is accepted, which also
   // keeps it steady while stage one stalls.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= req_push_value;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_pop_ok_ff <= s1_pop_ok_in;
         s1_occ_ff    <= s1_occ_in;
      end
      if (s1_move) begin
         s2_status_ff <= s1_status_ff;
         s2_popped_ff <= s1_pop_ok_ff ? rd_data_ff : '0;
         s2_occ_ff    <= s1_occ_ff;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_status       = s2_status_ff;
   assign rsp_popped_value = s2_popped_ff;
   assign rsp_occupancy    = s2_occ_ff;

endmodule

// ===== rtl/rbd_checker.sv =====
module rbd_checker #(
   parameter int unsigned DEPTH = rbd_pkg::DEPTH_DEFAULT
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rbd_pkg::STATUS_W-1:0]       rsp_status,
   input logic signed [rbd_pkg::WORD_W-1:0]  rsp_popped_value,
   input logic [rbd_pkg::OCC_W-1:0]          rsp_occupancy
);
   import rbd_pkg::*;

   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

   // A stalled response beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_value)
         && $stable(rsp_status) && $stable(rsp_occupancy))
      else $error("response beat changed while stalled");

   // Only a successful pop carries a word.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_popped_value == '0)
      else $error("failed request returned a nonzero word");

   // Overflow is reported only by a full queue.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OVERFLOW |-> rsp_occupancy == OCC_FULL)
      else $error("overflow reported while not full");

   // Underflow is reported only by an empty queue.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_UNDERFLOW |-> rsp_occupancy == '0)
      else $error("underflow reported while not empty");

   // The status code is one of the three defined outcomes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_DONE || rsp_status == STATUS_OVERFLOW
         || rsp_status == STATUS_UNDERFLOW)
      else $error("undefined status code");

endmodule

bind ring_buffer_deque_unit rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_popped_value (rsp_popped_value),
   .rsp_occupancy    (rsp_occupancy)
);
